// File: design/box_muller_gaussian_generator_unit_defines.svh
// Assertion macros for the Box-Muller generator.
// Included by the top level; no other dependencies.
`ifndef BOX_MULLER_GAUSSIAN_GENERATOR_UNIT_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check on every edge once reset is released
`define BMG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every edge, reset included
`define BMG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMG_ASSERT(label, prop, msg)
`define BMG_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: design/bmg_pkg.sv
// Shared types and constants of the Box-Muller generator.
// No dependencies.
`default_nettype none
package bmg_pkg;

  localparam int LOG_FRAC     = 28;
  localparam int CORDIC_STEPS = 24;

  // 2*ln(2) in Q.28 and the CORDIC gain compensation in Q.30
  localparam logic [28:0] TWO_LN2_Q28     = 29'd372130559;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  // Configuration register indexes
  localparam logic CFG_PHASE_OFFSET = 1'b0;
  localparam logic CFG_RADIUS_FLOOR = 1'b1;

  // Quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Pipeline control handed to every cell
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // atan(2^-k) in turns over 2^32
  function automatic logic [31:0] atan_turn(input int unsigned k);
    logic [31:0] a;
    case (k)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: design/bmg_log_cell.sv
// One squaring step of the log2 fraction: yields one fraction bit per beat.
// Depends on bmg_pkg.
`default_nettype none
module bmg_log_cell #(
  parameter int K     = 0,
  parameter int SIDEW = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bmg_pkg::pipe_ctl_t             ctl_i,
  input  logic [30:0]                    m_i,
  input  logic [bmg_pkg::LOG_FRAC-1:0]   frac_i,
  input  logic [SIDEW-1:0]               side_i,
  output logic                           vld_o,
  output logic [30:0]                    m_o,
  output logic [bmg_pkg::LOG_FRAC-1:0]   frac_o,
  output logic [SIDEW-1:0]               side_o
);
  import bmg_pkg::*;

  logic [61:0]          prod;
  logic [31:0]          sq;
  logic [30:0]          m_nxt;
  logic [LOG_FRAC-1:0]  frac_nxt;
  logic                 vld_r;
  logic [30:0]          m_r;
  logic [LOG_FRAC-1:0]  frac_r;
  logic [SIDEW-1:0]     side_r;

  // Square, renormalise and record the bit
  always_comb begin
    prod     = 62'(m_i) * 62'(m_i);
    sq       = prod[61:30];
    frac_nxt = frac_i;
    if (sq[31]) begin
      m_nxt = sq[31:1];
      frac_nxt[LOG_FRAC-1-K] = 1'b1;
    end else begin
      m_nxt = sq[30:0];
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign m_o    = m_r;
  assign frac_o = frac_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

// File: design/bmg_sqrt_cell.sv
// One digit of a restoring square root: two radicand bits in, one root bit out.
// Depends on bmg_pkg.
`default_nettype none
module bmg_sqrt_cell #(
  parameter int RW    = 28,
  parameter int VW    = 56,
  parameter int SIDEW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bmg_pkg::pipe_ctl_t ctl_i,
  input  logic [RW+1:0]      rem_i,
  input  logic [RW-1:0]      root_i,
  input  logic [VW-1:0]      v_i,
  input  logic [SIDEW-1:0]   side_i,
  output logic               vld_o,
  output logic [RW+1:0]      rem_o,
  output logic [RW-1:0]      root_o,
  output logic [VW-1:0]      v_o,
  output logic [SIDEW-1:0]   side_o
);
  import bmg_pkg::*;

  logic [RW+1:0]    remsh;
  logic [RW+1:0]    trial;
  logic [RW+1:0]    rem_nxt;
  logic [RW-1:0]    root_nxt;
  logic             vld_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [VW-1:0]    v_r;
  logic [SIDEW-1:0] side_r;

  // Bring down two bits and try the next root digit
  always_comb begin
    remsh = {rem_i[RW-1:0], v_i[VW-1 -: 2]};
    trial = {root_i, 2'b01};
    if (remsh >= trial) begin
      rem_nxt  = remsh - trial;
      root_nxt = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = remsh;
      root_nxt = {root_i[RW-2:0], 1'b0};
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      v_r    <= {v_i[VW-3:0], 2'b00};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign v_o    = v_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

// File: design/bmg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with angles in turns.
// Depends on bmg_pkg.
`default_nettype none
module bmg_cordic_cell #(
  parameter int K     = 0,
  parameter int XW    = 30,
  parameter int SIDEW = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmg_pkg::pipe_ctl_t    ctl_i,
  input  logic signed [XW-1:0]  x_i,
  input  logic signed [XW-1:0]  y_i,
  input  logic signed [31:0]    z_i,
  input  logic [SIDEW-1:0]      side_i,
  output logic                  vld_o,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic signed [31:0]    z_o,
  output logic [SIDEW-1:0]      side_o
);
  import bmg_pkg::*;

  localparam logic [31:0] ATAN = atan_turn(K);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [31:0]   z_nxt;
  logic                 vld_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [31:0]   z_r;
  logic [SIDEW-1:0]     side_r;

  // Rotate towards zero residual angle; zero counts as positive
  always_comb begin
    dx = y_i >>> K;
    dy = x_i >>> K;
    if (!z_i[31]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - signed'(ATAN);
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + signed'(ATAN);
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

// File: design/box_muller_gaussian_generator_unit.sv
// Box-Muller Gaussian pair generator: top level with the cell chains.
// Depends on bmg_pkg, bmg_log_cell, bmg_sqrt_cell, bmg_cordic_cell and the defines header.
`default_nettype none
`include "box_muller_gaussian_generator_unit_defines.svh"
// One Gaussian pair per clock from a stream of uniform pairs, unless an output beat is
// stalled. The block is a single pipeline: input clamp, a leading-zero normaliser
// ($clog2(UNIFORM_BITS) stages), 28 log2 squaring cells, three stages for -2 ln scaling,
// one square-root cell per root bit, a gain stage, 24 CORDIC cells, a quadrant stage and
// the output register. A new beat is taken every clock while no output beat is stalled.
// A stalled output beat freezes the whole pipeline, so in_stall follows out_stall while
// an output beat is waiting. Configuration takes effect on the next input beat; write it
// only while the pipeline is empty.
module box_muller_gaussian_generator_unit #(
  parameter int UNIFORM_BITS = 32,
  parameter int OUTPUT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [UNIFORM_BITS-1:0]       in_angle_uniform,
  input  logic [UNIFORM_BITS-1:0]       in_radius_uniform,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUTPUT_BITS-1:0] out_gauss_cos,
  output logic signed [OUTPUT_BITS-1:0] out_gauss_sin
);
  import bmg_pkg::*;

  localparam int UB   = UNIFORM_BITS;
  localparam int OB   = OUTPUT_BITS;
  localparam int CW   = $clog2(UB);
  localparam int NST  = CW;
  localparam int TW   = $clog2(UB + 1) + 28;
  localparam int TL   = 17;
  localparam int TH   = TW - TL;
  localparam int SW   = TW - 3;
  localparam int RW   = (SW + 24 + 1) / 2;
  localparam int VW   = 2 * RW;
  localparam int XW   = RW + 2;
  localparam int FO   = OB - 4;
  localparam int SHR  = (FO <= 24) ? 24 - FO : 0;
  localparam int SHL  = (FO > 24) ? FO - 24 : 0;
  localparam int RW0  = XW + 2 + SHL;
  localparam int RNDW = (RW0 > OB + 1) ? RW0 : OB + 1;
  localparam int LSW  = CW + 32;

  localparam logic signed [RNDW-1:0] HALF = (RNDW'(1) << SHR) >> 1;
  localparam logic signed [RNDW-1:0] HI   = (RNDW'(1) << (OB - 1)) - RNDW'(1);
  localparam logic signed [RNDW-1:0] LO   = -HI - RNDW'(1);

  // Round Q.24 to the output format and saturate
  function automatic logic signed [OB-1:0] to_out(input logic signed [XW:0] v);
    logic signed [RNDW-1:0] w;
    w = RNDW'(v);
    w = (w + HALF) >>> SHR;
    w = w <<< SHL;
    if (w > HI) begin
      w = HI;
    end else if (w < LO) begin
      w = LO;
    end
    return w[OB-1:0];
  endfunction

  // ---------------- control ----------------
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Configuration registers
  logic [15:0] phase_offset_r;
  logic [31:0] radius_floor_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_offset_r <= 16'd0;
      radius_floor_r <= 32'd42950;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_OFFSET: phase_offset_r <= cfg_wdata[15:0];
        CFG_RADIUS_FLOOR: radius_floor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  logic [UB+31:0] fl_wide;
  logic [UB-1:0]  fl;
  logic [UB-1:0]  u2_nxt;
  logic [UB+31:0] u1_wide;
  logic [31:0]    ang_nxt;
  logic           s0_vld_r;
  logic [UB-1:0]  s0_u2_r;
  logic [31:0]    s0_ang_r;

  // Clamp u2 to the floor and form the angle in turns
  always_comb begin
    fl_wide = {radius_floor_r, UB'(0)};
    fl      = fl_wide[UB+31:32];
    if (fl == '0) begin
      fl = UB'(1);
    end
    u2_nxt  = (in_radius_uniform < fl) ? fl : in_radius_uniform;
    u1_wide = {in_angle_uniform, 32'd0};
    ang_nxt = u1_wide[UB+31:UB] - {phase_offset_r, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u2_r  <= u2_nxt;
      s0_ang_r <= ang_nxt;
    end
  end

  // ---------------- normaliser ----------------
  logic          nrm_vld_r [NST];
  logic [UB-1:0] nrm_v_r   [NST];
  logic [CW-1:0] nrm_cnt_r [NST];
  logic [31:0]   nrm_ang_r [NST];

  for (genvar i = 0; i < NST; i++) begin : g_nrm
    localparam int S = 1 << (NST - 1 - i);
    logic          vld_in;
    logic [UB-1:0] v_in;
    logic [CW-1:0] cnt_in;
    logic [31:0]   ang_in;
    logic [UB-1:0] v_nxt;
    logic [CW-1:0] cnt_nxt;

    if (i == 0) begin : g_first
      assign vld_in = s0_vld_r;
      assign v_in   = s0_u2_r;
      assign cnt_in = '0;
      assign ang_in = s0_ang_r;
    end else begin : g_rest
      assign vld_in = nrm_vld_r[i-1];
      assign v_in   = nrm_v_r[i-1];
      assign cnt_in = nrm_cnt_r[i-1];
      assign ang_in = nrm_ang_r[i-1];
    end

    // Shift out a block of leading zeros
    always_comb begin
      if (v_in[UB-1 -: S] == '0) begin
        v_nxt   = v_in << S;
        cnt_nxt = cnt_in + CW'(S);
      end else begin
        v_nxt   = v_in;
        cnt_nxt = cnt_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nrm_vld_r[i] <= 1'b0;
      end else if (en) begin
        nrm_vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm_v_r[i]   <= v_nxt;
        nrm_cnt_r[i] <= cnt_nxt;
        nrm_ang_r[i] <= ang_in;
      end
    end
  end

  // ---------------- log2 chain ----------------
  logic                lg_vld  [LOG_FRAC+1];
  logic [30:0]         lg_m    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] lg_frac [LOG_FRAC+1];
  logic [LSW-1:0]      lg_side [LOG_FRAC+1];
  logic [UB+30:0]      nv_wide;

  assign nv_wide    = {nrm_v_r[NST-1], 31'd0};
  assign lg_vld[0]  = nrm_vld_r[NST-1];
  assign lg_m[0]    = nv_wide[UB+30 -: 31];
  assign lg_frac[0] = '0;
  assign lg_side[0] = {nrm_cnt_r[NST-1], nrm_ang_r[NST-1]};

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = lg_vld[k];
    bmg_log_cell #(.K(k), .SIDEW(LSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .m_i    (lg_m[k]),
      .frac_i (lg_frac[k]),
      .side_i (lg_side[k]),
      .vld_o  (lg_vld[k+1]),
      .m_o    (lg_m[k+1]),
      .frac_o (lg_frac[k+1]),
      .side_o (lg_side[k+1])
    );
  end

  // ---------------- -log2 and -2 ln scaling ----------------
  logic [CW-1:0]      lg_cnt;
  logic [TW-28-1:0]   p_inv;
  logic               t_vld_r;
  logic [TW-1:0]      t_r;
  logic [31:0]        t_ang_r;
  logic               ma_vld_r;
  logic [TL+28:0]     pl_r;
  logic [TH+28:0]     ph_r;
  logic [31:0]        ma_ang_r;
  logic [TW+29:0]     s_sum;
  logic               sb_vld_r;
  logic [SW-1:0]      s_r;
  logic [31:0]        sb_ang_r;

  assign lg_cnt = lg_side[LOG_FRAC][LSW-1:32];
  assign p_inv  = (TW-28)'(lg_cnt) + (TW-28)'(1);
  assign s_sum  = {1'b0, ph_r, TL'(0)} + (TW+30)'(pl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r  <= 1'b0;
      ma_vld_r <= 1'b0;
      sb_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r  <= lg_vld[LOG_FRAC];
      ma_vld_r <= t_vld_r;
      sb_vld_r <= ma_vld_r;
    end
  end

  // Form t, split the product into two partial products, then sum them
  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= {p_inv, 28'd0} - TW'(lg_frac[LOG_FRAC]);
      t_ang_r  <= lg_side[LOG_FRAC][31:0];
      pl_r     <= (TL+29)'(t_r[TL-1:0]) * (TL+29)'(TWO_LN2_Q28);
      ph_r     <= (TH+29)'(t_r[TW-1:TL]) * (TH+29)'(TWO_LN2_Q28);
      ma_ang_r <= t_ang_r;
      s_r      <= s_sum[TW+28:32];
      sb_ang_r <= ma_ang_r;
    end
  end

  // ---------------- square root chain ----------------
  logic          sq_vld  [RW+1];
  logic [RW+1:0] sq_rem  [RW+1];
  logic [RW-1:0] sq_root [RW+1];
  logic [VW-1:0] sq_v    [RW+1];
  logic [31:0]   sq_side [RW+1];

  assign sq_vld[0]  = sb_vld_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = VW'({s_r, 24'd0});
  assign sq_side[0] = sb_ang_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = sq_vld[k];
    bmg_sqrt_cell #(.RW(RW), .VW(VW), .SIDEW(32)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .v_i    (sq_v[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .v_o    (sq_v[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // ---------------- gain and angle split ----------------
  logic [RW+29:0]       gprod;
  logic [31:0]          as_ang;
  logic                 g_vld_r;
  logic signed [XW-1:0] g_x_r;
  logic signed [31:0]   g_z_r;
  logic [1:0]           g_q_r;

  assign gprod  = (RW+30)'(sq_root[RW]) * (RW+30)'(CORDIC_GAIN_Q30);
  assign as_ang = sq_side[RW] + 32'h2000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= sq_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_x_r <= signed'(XW'(gprod[RW+29:30]));
      g_z_r <= signed'({2'b00, as_ang[29:0]}) - 32'sh2000_0000;
      g_q_r <= as_ang[31:30];
    end
  end

  // ---------------- CORDIC chain ----------------
  logic                 cd_vld [CORDIC_STEPS+1];
  logic signed [XW-1:0] cd_x   [CORDIC_STEPS+1];
  logic signed [XW-1:0] cd_y   [CORDIC_STEPS+1];
  logic signed [31:0]   cd_z   [CORDIC_STEPS+1];
  logic [1:0]           cd_q   [CORDIC_STEPS+1];

  assign cd_vld[0] = g_vld_r;
  assign cd_x[0]   = g_x_r;
  assign cd_y[0]   = '0;
  assign cd_z[0]   = g_z_r;
  assign cd_q[0]   = g_q_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = cd_vld[k];
    bmg_cordic_cell #(.K(k), .XW(XW), .SIDEW(2)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .x_i    (cd_x[k]),
      .y_i    (cd_y[k]),
      .z_i    (cd_z[k]),
      .side_i (cd_q[k]),
      .vld_o  (cd_vld[k+1]),
      .x_o    (cd_x[k+1]),
      .y_o    (cd_y[k+1]),
      .z_o    (cd_z[k+1]),
      .side_o (cd_q[k+1])
    );
  end

  // ---------------- quadrant rotation ----------------
  logic signed [XW:0] xe;
  logic signed [XW:0] ye;
  logic signed [XW:0] rx_nxt;
  logic signed [XW:0] ry_nxt;
  logic               rt_vld_r;
  logic signed [XW:0] rt_x_r;
  logic signed [XW:0] rt_y_r;

  assign xe = (XW+1)'(cd_x[CORDIC_STEPS]);
  assign ye = (XW+1)'(cd_y[CORDIC_STEPS]);

  always_comb begin
    case (cd_q[CORDIC_STEPS])
      QUAD_1: begin
        rx_nxt = -ye;
        ry_nxt = xe;
      end
      QUAD_2: begin
        rx_nxt = -xe;
        ry_nxt = -ye;
      end
      QUAD_3: begin
        rx_nxt = ye;
        ry_nxt = -xe;
      end
      default: begin
        rx_nxt = xe;
        ry_nxt = ye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r <= 1'b0;
    end else if (en) begin
      rt_vld_r <= cd_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_x_r <= rx_nxt;
      rt_y_r <= ry_nxt;
    end
  end

  // ---------------- output register ----------------
  logic                 out_valid_r;
  logic signed [OB-1:0] out_cos_r;
  logic signed [OB-1:0] out_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos_r <= to_out(rt_x_r);
      out_sin_r <= to_out(rt_y_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_gauss_cos = out_cos_r;
  assign out_gauss_sin = out_sin_r;

  // ---------------- assertions ----------------
  `BMG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output beat right after reset")
  `BMG_ASSERT(a_accept_enters, in_valid && !in_stall |=> s0_vld_r, "accepted beat not in pipe")
  `BMG_ASSERT(a_freeze, out_valid && out_stall |=> $stable(cd_vld[CORDIC_STEPS/2]), "pipe moved under stall")

endmodule
`default_nettype wire
